>>> src/tts_pkg.sv
package tts_pkg;

   // Table geometry
   localparam int NUM_SLOTS       = 16;
   localparam int DELAY_WIDTH     = 16;
   localparam int RUN_COUNT_WIDTH = 8;
   localparam int MAX_RESULTS     = 16;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

   // Operation codes
   localparam logic [1:0] OP_ADD      = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_DISPATCH = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_ADDED = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] start_delay;
      logic [15:0] repeat_period;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] slot;
      logic       last;
   } rsp_type;

   // One slot entry as kept in the slot RAM
   typedef struct packed {
      logic [DELAY_WIDTH-1:0]     delay;
      logic [DELAY_WIDTH-1:0]     period;
      logic [RUN_COUNT_WIDTH-1:0] pending;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control from the slot unit to the sequencer
   typedef struct packed {
      logic wr_en;
      logic set_valid;
      logic clr_valid;
      logic found;
   } slot_ctl_type;

endpackage

>>> src/time_triggered_task_scheduler_core.sv
// Time-triggered task scheduler. Start an item with start while busy is low;
// op selects add, tick or dispatch (op 3 is ignored). The slot table lives in
// a single RAM that a small sequencer walks one slot per cycle through one
// shared update unit. Tick walks every slot and returns nothing; dispatch
// may stop early at MAX_RESULTS tasks, and add ends at the first free slot.
// Results come out on rsp_valid for one cycle each and cannot be held off,
// so the receiver must take every strobe; rsp_item.last marks the final
// result of an item, after which busy drops in the same cycle. A dispatch
// reports at most MAX_RESULTS tasks.
module time_triggered_task_scheduler_core import tts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PRIME = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 hold_vld_ff, hold_vld_in;
   logic [3:0]           hold_slot_ff, hold_slot_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   req_type              req_ff, req_in;

   logic [ENTRY_W-1:0]   rd_data;
   logic [SLOT_W-1:0]    rd_addr;
   entry_type            rd_entry;
   entry_type            new_entry;
   slot_ctl_type         ctl;
   logic                 is_last_idx;
   logic                 room;
   logic [CNT_W-1:0]     cnt_next;

   assign is_last_idx = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
   assign room        = (cnt_ff != CNT_W'(MAX_RESULTS));
   assign cnt_next    = CNT_W'(cnt_ff + 1'b1);
   assign rd_entry    = entry_type'(rd_data);

   // Read one slot ahead of the one being updated
   assign rd_addr = (state_ff == S_WALK && !is_last_idx) ? SLOT_W'(idx_ff + 1'b1) : idx_ff;

   tts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (state_ff == S_WALK && ctl.wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tts_slot_alu u_slot_alu (
      .op            (req_ff.op),
      .slot_valid    (valid_ff[idx_ff]),
      .entry         (rd_entry),
      .start_delay   (req_ff.start_delay),
      .repeat_period (req_ff.repeat_period),
      .room          (room),
      .new_entry     (new_entry),
      .ctl           (ctl)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      hold_vld_in  = hold_vld_ff;
      hold_slot_in = hold_slot_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in      = req_item;
               idx_in      = '0;
               cnt_in      = '0;
               hold_vld_in = 1'b0;
               if (req_item.op == OP_ADD || req_item.op == OP_TICK ||
                   req_item.op == OP_DISPATCH) begin
                  state_in = S_PRIME;
               end
            end
         end
         S_PRIME: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (ctl.set_valid) begin
               valid_in[idx_ff] = 1'b1;
            end
            if (ctl.clr_valid) begin
               valid_in[idx_ff] = 1'b0;
            end
            case (req_ff.op)
               OP_ADD: begin
                  if (ctl.found) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_ADDED, slot: 4'(idx_ff), last: 1'b1};
                     state_in     = S_IDLE;
                  end else if (is_last_idx) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_FULL, slot: 4'd0, last: 1'b1};
                     state_in     = S_IDLE;
                  end else begin
                     idx_in = SLOT_W'(idx_ff + 1'b1);
                  end
               end
               OP_TICK: begin
                  if (is_last_idx) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in = SLOT_W'(idx_ff + 1'b1);
                  end
               end
               OP_DISPATCH: begin
                  // keep one found item back so the final one can carry last
                  if (ctl.found) begin
                     cnt_in       = cnt_next;
                     hold_vld_in  = 1'b1;
                     hold_slot_in = 4'(idx_ff);
                     if (hold_vld_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{status: ST_RUN, slot: hold_slot_ff, last: 1'b0};
                     end
                  end
                  if (is_last_idx || (ctl.found && cnt_next == CNT_W'(MAX_RESULTS))) begin
                     state_in = S_FIN;
                  end else begin
                     idx_in = SLOT_W'(idx_ff + 1'b1);
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            if (hold_vld_ff) begin
               rsp_in = '{status: ST_RUN, slot: hold_slot_ff, last: 1'b1};
            end else begin
               rsp_in = '{status: ST_NONE, slot: 4'd0, last: 1'b1};
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      hold_vld_ff  <= hold_vld_in;
      hold_slot_ff <= hold_slot_in;
      rsp_ff       <= rsp_in;
      req_ff       <= req_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   // Results only come from the walk or the finish step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_WALK || $past(state_ff) == S_FIN))
      else $error("result without a walk");

   // A final result leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> (state_ff == S_IDLE))
      else $error("busy after final result");

   // A real operation makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.op == OP_ADD || req_item.op == OP_TICK ||
                          req_item.op == OP_DISPATCH)) |=> busy)
      else $error("item accepted without going busy");

   // Dispatch never counts past its result limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK || state_ff == S_FIN) |-> (cnt_ff <= CNT_W'(MAX_RESULTS)))
      else $error("dispatch count overflow");

   // A tick never frees or claims a slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && req_ff.op == OP_TICK) |=> (valid_ff == $past(valid_ff)))
      else $error("tick changed slot occupancy");
`endif

endmodule

>>> src/tts_ram.sv
module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tts_slot_alu.sv
module tts_slot_alu import tts_pkg::*; (
   input  logic [1:0]   op,
   input  logic         slot_valid,
   input  entry_type    entry,
   input  logic [15:0]  start_delay,
   input  logic [15:0]  repeat_period,
   input  logic         room,
   output entry_type    new_entry,
   output slot_ctl_type ctl
);

   // Per-slot update, shared by every step of the walk
   always_comb begin
      new_entry = entry;
      ctl       = '0;
      case (op)
         OP_ADD: begin
            if (!slot_valid) begin
               new_entry.delay   = DELAY_WIDTH'(start_delay);
               new_entry.period  = DELAY_WIDTH'(repeat_period);
               new_entry.pending = '0;
               ctl.wr_en         = 1'b1;
               ctl.set_valid     = 1'b1;
               ctl.found         = 1'b1;
            end
         end
         OP_TICK: begin
            if (slot_valid) begin
               ctl.wr_en = 1'b1;
               if (entry.delay == '0) begin
                  // saturating run count, reload when periodic
                  if (entry.pending != '1) begin
                     new_entry.pending = entry.pending + 1'b1;
                  end
                  if (entry.period != '0) begin
                     new_entry.delay = entry.period;
                  end
               end else begin
                  new_entry.delay = entry.delay - 1'b1;
               end
            end
         end
         OP_DISPATCH: begin
            if (slot_valid && entry.pending != '0 && room) begin
               new_entry.pending = entry.pending - 1'b1;
               ctl.wr_en         = 1'b1;
               ctl.found         = 1'b1;
               ctl.clr_valid     = (entry.period == '0);
            end
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule
